### rtl/cfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the CSV field extractor.
// No dependencies; cfe_step and csv_field_extractor_core import this package.
package cfe_pkg;

  // Column and value length bounds
  localparam int unsigned MAX_COLUMNS     = 256;
  localparam int unsigned MAX_VALUE_BYTES = 4096;

  // Field widths
  localparam int unsigned REC_W  = 24;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned FCNT_W = 9;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned CFG_DATA_W = 24;

  // Characters the parser reacts to
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_EOF   = 8'h00;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic {
    REG_RECORD_COUNT = 1'b0,
    REG_COL_TOTAL    = 1'b1
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    cmd_e              command;
    logic [REC_W-1:0]  rec_sel;
    logic [COL_W-1:0]  col_sel;
    logic [LEN_W-1:0]  max_length;
    logic [7:0]        data_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_e           status;
    logic [7:0]        out_byte;
    logic [LEN_W-1:0]  length;
    logic              last;
  } out_item_t;

  // Lookup state carried from item to item
  typedef struct packed {
    logic              busy;
    logic [COL_W-1:0]  target_column;
    logic [COL_W-1:0]  column_counter;
    logic              in_quotes;
    logic [LEN_W-1:0]  copied_count;
    logic [LEN_W-1:0]  length_limit;
  } lookup_state_t;

  // Table geometry from the configuration registers
  typedef struct packed {
    logic [REC_W-1:0]  record_count;
    logic [FCNT_W-1:0] col_total;
  } table_cfg_t;

endpackage

### rtl/cfe_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// Payload types come from cfe_pkg at instantiation.
interface cfe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/cfe_step.sv
`timescale 1ns / 1ps
// Per-item update of the lookup: next state and the optional result item.
// Purely combinational; depends on cfe_pkg.
module cfe_step (
  input  cfe_pkg::lookup_state_t state_q_i,
  input  cfe_pkg::table_cfg_t    cfg_i,
  input  cfe_pkg::in_item_t      item_i,
  output cfe_pkg::lookup_state_t state_d_o,
  output logic                   res_valid_o,
  output cfe_pkg::out_item_t     res_o
);
  import cfe_pkg::*;

  logic [FCNT_W-1:0] cols;
  logic [LEN_W-1:0]  limit_sat;
  logic              start_bad;
  logic              at_target;
  logic              is_quote;
  logic              ends_field;
  logic [7:0]        b;

  // Saturate the column count and the length limit
  assign cols      = (cfg_i.col_total > FCNT_W'(MAX_COLUMNS))
                     ? FCNT_W'(MAX_COLUMNS) : cfg_i.col_total;
  assign limit_sat = (item_i.max_length > LEN_W'(MAX_VALUE_BYTES))
                     ? LEN_W'(MAX_VALUE_BYTES) : item_i.max_length;
  assign start_bad = (item_i.rec_sel >= cfg_i.record_count)
                  || ({1'b0, item_i.col_sel} >= cols);

  // Byte classification
  assign b          = item_i.data_byte;
  assign at_target  = (state_q_i.column_counter == state_q_i.target_column);
  assign is_quote   = (b == CHR_QUOTE);
  assign ends_field = is_quote
                   || (!state_q_i.in_quotes
                       && ((b == CHR_COMMA) || (b == CHR_LF) || (b == CHR_CR)));

  // Next state and result
  always_comb begin
    state_d_o       = state_q_i;
    res_valid_o     = 1'b0;
    res_o.status    = ST_BYTE;
    res_o.out_byte  = '0;
    res_o.length    = '0;
    res_o.last      = 1'b0;
    unique case (item_i.command)
      CMD_START: begin
        state_d_o.busy = 1'b0;
        if (start_bad) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_ERROR;
          res_o.last   = 1'b1;
        end else begin
          state_d_o.busy           = 1'b1;
          state_d_o.target_column  = item_i.col_sel;
          state_d_o.column_counter = '0;
          state_d_o.in_quotes      = 1'b0;
          state_d_o.copied_count   = '0;
          state_d_o.length_limit   = limit_sat;
        end
      end
      CMD_DATA: begin
        if (state_q_i.busy) begin
          priority if (b == CHR_EOF) begin
            // End of file closes the value or fails the lookup
            res_valid_o    = 1'b1;
            res_o.last     = 1'b1;
            state_d_o.busy = 1'b0;
            if (at_target) begin
              res_o.status = ST_DONE;
              res_o.length = state_q_i.copied_count;
            end else begin
              res_o.status = ST_ERROR;
            end
          end else if ((state_q_i.copied_count == '0) && is_quote) begin
            // Drop the quote, flip the quoted flag
            state_d_o.in_quotes = !state_q_i.in_quotes;
          end else if (at_target) begin
            res_valid_o = 1'b1;
            if (ends_field) begin
              res_o.status   = ST_DONE;
              res_o.length   = state_q_i.copied_count;
              res_o.last     = 1'b1;
              state_d_o.busy = 1'b0;
            end else if (state_q_i.copied_count >= state_q_i.length_limit) begin
              res_o.status   = ST_ERROR;
              res_o.last     = 1'b1;
              state_d_o.busy = 1'b0;
            end else begin
              res_o.status           = ST_BYTE;
              res_o.out_byte         = b;
              state_d_o.copied_count = state_q_i.copied_count + LEN_W'(1);
            end
          end else begin
            // Skip columns ahead of the wanted one; a line feed here fails the lookup
            if (!state_q_i.in_quotes && (b == CHR_COMMA)) begin
              state_d_o.column_counter = state_q_i.column_counter + COL_W'(1);
            end
            if (b == CHR_LF) begin
              res_valid_o    = 1'b1;
              res_o.status   = ST_ERROR;
              res_o.last     = 1'b1;
              state_d_o.busy = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d_o = state_q_i;
      end
    endcase
  end

endmodule

### rtl/csv_field_extractor_core.sv
`timescale 1ns / 1ps
// CSV field extractor top level: config registers, lookup state, result buffer.
// Depends on cfe_pkg, cfe_stream_if and cfe_step.
//
//   channel  | dir | payload     | handshake
//   ---------+-----+-------------+-------------------------------
//   in_i     | in  | in_item_t   | valid/ready, accept on both high
//   out_o    | out | out_item_t  | valid/ready, accept on both high
//   cfg      | in  | idx + data  | write on cfg_we_i, no wait
//
// One item per cycle while in_i.ready is high: each accepted item updates the
// lookup state in the cycle it is taken, and its result (if any) is registered
// in the output register or, behind a waiting result, in the skid entry.
// Reset clears the lookup to idle, record_count to 0 and the column total to 1.
// A two-entry result buffer (output register plus skid) keeps input ready
// while one result waits; in_i.ready drops only when both entries are full.
module csv_field_extractor_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  cfe_pkg::cfg_reg_e                  cfg_idx_i,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  cfe_stream_if.sink                         in_i,
  cfe_stream_if.source                       out_o
);
  import cfe_pkg::*;

  table_cfg_t    cfg_q;
  lookup_state_t state_q, state_d;
  out_item_t     res;
  logic          res_valid;
  out_item_t     out_q, skid_q;
  logic          out_valid_q, skid_valid_q;
  logic          accept, push, pop;
  in_item_t      item;

  assign item   = in_i.data;
  assign accept = in_i.valid && in_i.ready;
  assign push   = accept && res_valid;
  assign pop    = out_valid_q && out_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_count <= '0;
      cfg_q.col_total    <= FCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RECORD_COUNT: cfg_q.record_count <= cfg_wdata_i[REC_W-1:0];
        REG_COL_TOTAL:    cfg_q.col_total    <= cfg_wdata_i[FCNT_W-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  cfe_step u_step (
    .state_q_i   (state_q),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .state_d_o   (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Advance the lookup state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result buffer occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push && out_valid_q && !pop) begin
      skid_valid_q <= 1'b1;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push && out_valid_q && !pop) begin
      skid_q <= res;
    end else if (push) begin
      out_q <= res;
    end
  end

  assign in_i.ready  = !skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // A closing result leaves the lookup idle
  a_last_ends_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.last) |=> !state_q.busy)
    else $error("lookup still busy after final result");

  // Every emitted value byte counts once
  a_byte_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (res.status == ST_BYTE))
      |=> (state_q.copied_count == $past(state_q.copied_count) + LEN_W'(1)))
    else $error("copied count out of step with emitted bytes");

  // Copy never runs past the limit
  a_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.busy |-> (state_q.copied_count <= state_q.length_limit))
    else $error("copied count above length limit");

  // Only byte results keep the lookup open
  a_last_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (res.last == (res.status != ST_BYTE)))
    else $error("last flag disagrees with status");

endmodule
